### hw/rtl/general_modulus_lcg_top_defines.svh
// Assertion macros shared by the general modulus LCG RTL.
// No dependencies; include by bare file name.
`ifndef GENERAL_MODULUS_LCG_TOP_DEFINES_SVH
`define GENERAL_MODULUS_LCG_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// property checked on every clock edge outside reset
`define GML_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// implication checked on every clock edge outside reset
`define GML_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define GML_ASSERT(lbl, prop, msg)
`define GML_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

### hw/rtl/gml_pkg.sv
// Shared types and constants for the general modulus LCG.
// No dependencies.
`timescale 1ns / 1ps
package gml_pkg;
  localparam int WORD_W            = 64;
  localparam int STATUS_W          = 3;
  localparam int FRACTION_BITS_DEF = 32;
  localparam int CFG_IDX_W         = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MULTIPLIER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INCREMENT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MODE  = 2'd3;

  // reset values of the configuration registers
  localparam logic [WORD_W-1:0] MODULUS_RST    = 64'd2147483647;
  localparam logic [WORD_W-1:0] MULTIPLIER_RST = 64'd16807;

  // parameter check codes
  localparam logic [STATUS_W-1:0] STS_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] STS_BAD_PARAMS = 3'd1;
  localparam logic [STATUS_W-1:0] STS_OVERFLOW   = 3'd2;
  localparam logic [STATUS_W-1:0] STS_SEED_RANGE = 3'd3;
  localparam logic [STATUS_W-1:0] STS_FIXED_PT   = 3'd4;

  // controller to datapath commands
  typedef struct packed {
    logic capture;       // take input transaction, load first multiply
    logic mul_step;
    logic mul_load_chk;  // load (modulus-1)*multiplier
    logic div_load_mod;
    logic div_load_frac;
    logic div_step;
    logic next_latch;
    logic cnt_clr;
    logic out_load;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic last_word;
    logic last_frac;
    logic op_load;
    logic out_busy;
  } sts_t;
endpackage

### hw/rtl/gml_datapath.sv
// Datapath: state register, shift-add multiplier, restoring divider, output register.
// Depends on gml_pkg.
`timescale 1ns / 1ps
module gml_datapath #(
  parameter int FB = gml_pkg::FRACTION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [gml_pkg::WORD_W-1:0]      modulus,
  input  logic [gml_pkg::WORD_W-1:0]      multiplier,
  input  logic [gml_pkg::WORD_W-1:0]      increment,
  input  logic                            zero_mode,
  input  logic                            in_operation,
  input  logic [gml_pkg::WORD_W-1:0]      in_seed_value,
  input  gml_pkg::cmd_t                   cmd,
  output gml_pkg::sts_t                   sts,
  input  logic                            out_stall,
  output logic                            out_valid,
  output logic [gml_pkg::WORD_W-1:0]      out_state_value,
  output logic [FB:0]                     out_fraction,
  output logic [gml_pkg::STATUS_W-1:0]    out_status
);
  import gml_pkg::*;

  localparam int CNT_W = $clog2(WORD_W);

  logic [WORD_W-1:0]   cur_state_r, seed_r, mcand_r, mlo_r, acc_r, rem_r, dvd_r, next_r;
  logic [WORD_W-1:0]   cur_state_nxt, seed_nxt, mcand_nxt, mlo_nxt, acc_nxt, rem_nxt;
  logic [WORD_W-1:0]   dvd_nxt, next_nxt;
  logic                op_r, op_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]   out_state_r, out_state_nxt;
  logic [FB:0]         out_frac_r, out_frac_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;

  logic [WORD_W:0]     psum;
  logic                top, sub;
  logic [WORD_W-1:0]   sh;
  logic                chk1, chk2, chk3, chk4;
  logic [FB-1:0]       quot, half;
  logic [FB:0]         frac_zero, frac_val;

  // shift-add multiply step, one multiplier bit per cycle
  assign psum = {1'b0, acc_r} + (mlo_r[0] ? {1'b0, mcand_r} : '0);

  // restoring divide step; a zero modulus stands for 2^64
  assign top = rem_r[WORD_W-1];
  assign sh  = {rem_r[WORD_W-2:0], dvd_r[WORD_W-1]};
  assign sub = top || ((modulus != '0) && (sh >= modulus));

  // parameter checks, evaluated once every phase has finished
  assign chk1 = !((multiplier != '0) && (multiplier < modulus) && (increment < modulus));
  assign chk2 = (acc_r != '0) || (mlo_r > ~increment);
  assign chk3 = seed_r >= modulus;
  assign chk4 = next_r == seed_r;

  // fraction of a zero state
  assign quot = dvd_r[FB-1:0];
  assign half = quot >> 1;
  always_comb begin
    if (zero_mode) begin
      frac_zero = (FB+1)'(1) << FB;
    end else if (modulus == '0) begin
      frac_zero = (FB+1)'(1);
    end else if (modulus == WORD_W'(1)) begin
      frac_zero = (FB+1)'(1) << (FB - 1);
    end else if (half == '0) begin
      frac_zero = (FB+1)'(1);
    end else begin
      frac_zero = {1'b0, half};
    end
  end

  always_comb begin
    if (op_r) begin
      frac_val = '0;
    end else if (next_r == '0) begin
      frac_val = frac_zero;
    end else begin
      frac_val = {1'b0, quot};
    end
  end

  // next-state logic
  always_comb begin
    cur_state_nxt  = cur_state_r;
    seed_nxt       = seed_r;
    op_nxt         = op_r;
    mcand_nxt      = mcand_r;
    mlo_nxt        = mlo_r;
    acc_nxt        = acc_r;
    rem_nxt        = rem_r;
    dvd_nxt        = dvd_r;
    next_nxt       = next_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_state_nxt  = out_state_r;
    out_frac_nxt   = out_frac_r;
    out_status_nxt = out_status_r;

    if (cmd.capture) begin
      op_nxt    = in_operation;
      seed_nxt  = in_operation ? in_seed_value : cur_state_r;
      mcand_nxt = multiplier;
      mlo_nxt   = in_operation ? in_seed_value : cur_state_r;
      acc_nxt   = '0;
    end
    if (cmd.mul_load_chk) begin
      mcand_nxt = multiplier;
      mlo_nxt   = modulus - WORD_W'(1);
      acc_nxt   = '0;
    end
    if (cmd.mul_step) begin
      acc_nxt = psum[WORD_W:1];
      mlo_nxt = {psum[0], mlo_r[WORD_W-1:1]};
    end
    if (cmd.div_load_mod) begin
      rem_nxt = '0;
      dvd_nxt = mlo_r + increment;
    end
    if (cmd.div_load_frac) begin
      rem_nxt = (next_r == '0) ? WORD_W'(1) : next_r;
      dvd_nxt = '0;
    end
    if (cmd.div_step) begin
      rem_nxt = sub ? sh - modulus : sh;
      dvd_nxt = {dvd_r[WORD_W-2:0], sub};
    end
    if (cmd.next_latch) begin
      next_nxt = rem_r;
    end
    if (cmd.cnt_clr) begin
      cnt_nxt = '0;
    end else if (cmd.mul_step || cmd.div_step) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      out_state_nxt = op_r ? seed_r : next_r;
      cur_state_nxt = op_r ? seed_r : next_r;
      out_frac_nxt  = frac_val;
      if (chk1) begin
        out_status_nxt = STS_BAD_PARAMS;
      end else if (chk2) begin
        out_status_nxt = STS_OVERFLOW;
      end else if (chk3) begin
        out_status_nxt = STS_SEED_RANGE;
      end else if (chk4) begin
        out_status_nxt = STS_FIXED_PT;
      end else begin
        out_status_nxt = STS_OK;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_state_r <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      cur_state_r <= cur_state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    seed_r       <= seed_nxt;
    op_r         <= op_nxt;
    mcand_r      <= mcand_nxt;
    mlo_r        <= mlo_nxt;
    acc_r        <= acc_nxt;
    rem_r        <= rem_nxt;
    dvd_r        <= dvd_nxt;
    next_r       <= next_nxt;
    out_state_r  <= out_state_nxt;
    out_frac_r   <= out_frac_nxt;
    out_status_r <= out_status_nxt;
  end

  assign sts.last_word = &cnt_r;
  assign sts.last_frac = cnt_r == CNT_W'(FB - 1);
  assign sts.op_load   = op_r;
  assign sts.out_busy  = out_valid_r && out_stall;

  assign out_valid       = out_valid_r;
  assign out_state_value = out_state_r;
  assign out_fraction    = out_frac_r;
  assign out_status      = out_status_r;
endmodule

### hw/rtl/gml_ctrl.sv
// Controller: sequences multiply, modulo, check multiply and fraction phases.
// Depends on gml_pkg and general_modulus_lcg_top_defines.svh.
`timescale 1ns / 1ps
`include "general_modulus_lcg_top_defines.svh"
module gml_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  gml_pkg::sts_t sts,
  output gml_pkg::cmd_t cmd
);
  import gml_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MUL1  = 9'b000000010,
    S_MODL  = 9'b000000100,
    S_MOD   = 9'b000001000,
    S_MUL2L = 9'b000010000,
    S_MUL2  = 9'b000100000,
    S_FRACL = 9'b001000000,
    S_FRAC  = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_stall = state_r != S_IDLE;
  assign accept   = in_valid && !in_stall;

  // phase sequencing and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul_step = 1'b1;
        if (sts.last_word) state_nxt = S_MODL;
      end
      S_MODL: begin
        cmd.div_load_mod = 1'b1;
        cmd.cnt_clr      = 1'b1;
        state_nxt        = S_MOD;
      end
      S_MOD: begin
        cmd.div_step = 1'b1;
        if (sts.last_word) state_nxt = S_MUL2L;
      end
      S_MUL2L: begin
        cmd.next_latch   = 1'b1;
        cmd.mul_load_chk = 1'b1;
        cmd.cnt_clr      = 1'b1;
        state_nxt        = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_step = 1'b1;
        if (sts.last_word) state_nxt = sts.op_load ? S_FIN : S_FRACL;
      end
      S_FRACL: begin
        cmd.div_load_frac = 1'b1;
        cmd.cnt_clr       = 1'b1;
        state_nxt         = S_FRAC;
      end
      S_FRAC: begin
        cmd.div_step = 1'b1;
        if (sts.last_frac) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `GML_ASSERT(a_accept_starts, accept |=> (state_r == S_MUL1), "accept did not start multiply")
  `GML_ASSERT_IMPL(a_no_overwrite, cmd.out_load, !sts.out_busy, "result register overwritten")
  `GML_ASSERT(a_frac_ends, (state_r == S_FRAC) && sts.last_frac |=> (state_r == S_FIN), "fraction phase overran")
endmodule

### hw/rtl/general_modulus_lcg_top.sv
// One transaction at a time; a draw runs the multiply, modulo, check multiply and fraction
// phases, a load skips the fraction phase. The pace is set by the bit-serial shift-add
// multiplier and restoring divider; a held result can delay the end of a transaction.
// A finished result waits in an output register while the next transaction starts.
// Top level (config registers, controller, datapath); sync active-low reset initialises
// config registers, controller state, current state, step counter and output valid.
`timescale 1ns / 1ps
module general_modulus_lcg_top #(
  parameter int FRACTION_BITS = gml_pkg::FRACTION_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_operation,
  input  logic [gml_pkg::WORD_W-1:0]       in_seed_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [gml_pkg::WORD_W-1:0]       out_state_value,
  output logic [FRACTION_BITS:0]           out_fraction,
  output logic [gml_pkg::STATUS_W-1:0]     out_status,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gml_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gml_pkg::WORD_W-1:0]       cfg_data
);
  import gml_pkg::*;

  logic [WORD_W-1:0] modulus_r, multiplier_r, increment_r;
  logic              zero_mode_r;
  cmd_t              cmd;
  sts_t              sts;

  assign cfg_ready = 1'b1;

  // configuration register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r    <= MODULUS_RST;
      multiplier_r <= MULTIPLIER_RST;
      increment_r  <= '0;
      zero_mode_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MODULUS:    modulus_r    <= cfg_data;
        CFG_MULTIPLIER: multiplier_r <= cfg_data;
        CFG_INCREMENT:  increment_r  <= cfg_data;
        CFG_ZERO_MODE:  zero_mode_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  gml_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  gml_datapath #(
    .FB (FRACTION_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .modulus         (modulus_r),
    .multiplier      (multiplier_r),
    .increment       (increment_r),
    .zero_mode       (zero_mode_r),
    .in_operation    (in_operation),
    .in_seed_value   (in_seed_value),
    .cmd             (cmd),
    .sts             (sts),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_state_value (out_state_value),
    .out_fraction    (out_fraction),
    .out_status      (out_status)
  );
endmodule
